// ===== rtl/core/ussc_pkg.sv =====
// Package: constants, tables and types shared by the search space candidate block
`default_nettype none
package ussc_pkg;

  localparam int RNTI_W  = 16;
  localparam int SF_W    = 4;
  localparam int SIZE_W  = 7;
  localparam int CCE_W   = 7;
  localparam int LVL_W   = 2;
  localparam int Y_W     = 17;
  localparam int PROD_W  = 32;
  localparam int CAND_W  = 3;
  localparam int DCNT_W  = $clog2(Y_W + 1);

  localparam logic [15:0]  HASH_MULT = 16'd39827;
  localparam logic [17:0]  HASH_MOD  = 18'd65537;

  localparam logic [LVL_W-1:0] LVL_TOP = 2'd3;
  localparam logic [LVL_W-1:0] LVL_ONE = 2'd0;

  // candidates per level before capping, indexed by log2 of the level
  localparam logic [CAND_W-1:0] CAND_LIMIT [4] = '{3'd6, 3'd6, 3'd2, 3'd2};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HMUL,
    ST_HRED,
    ST_LVL,
    ST_DIV,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic             start;
    logic [Y_W-1:0]   dividend;
    logic [CCE_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [CCE_W-1:0] rem;
  } rem_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/ussc_if.sv =====
// Interfaces: input item channel and candidate result channel
`default_nettype none
interface ussc_in_if;
  logic                         valid;
  logic                         ready;
  logic [ussc_pkg::RNTI_W-1:0]  rnti;
  logic [ussc_pkg::SF_W-1:0]    subframe;
  logic [ussc_pkg::SIZE_W-1:0]  payload_bits;

  modport source (output valid, output rnti, output subframe, output payload_bits,
                  input ready);
  modport sink   (input valid, input rnti, input subframe, input payload_bits,
                  output ready);
endinterface

interface ussc_out_if;
  logic                         valid;
  logic                         ready;
  logic [ussc_pkg::LVL_W-1:0]   level_log2;
  logic [ussc_pkg::CCE_W-1:0]   start_cce;
  logic [ussc_pkg::SIZE_W-1:0]  size_echo;
  logic                         last;

  modport source (output valid, output level_log2, output start_cce, output size_echo,
                  output last, input ready);
  modport sink   (input valid, input level_log2, input start_cce, input size_echo,
                  input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ussc_hash_step.sv =====
// Hash step: registered multiply by 39827, then reduction modulo 65537
`default_nettype none
module ussc_hash_step (
  input  wire logic                      clk,
  input  wire logic                      load,
  input  wire logic [ussc_pkg::Y_W-1:0]  y_in,
  output logic      [ussc_pkg::Y_W-1:0]  y_out
);

  logic [ussc_pkg::PROD_W-1:0] prod_r;
  logic [17:0]                 diff;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= ussc_pkg::PROD_W'(ussc_pkg::HASH_MULT) * ussc_pkg::PROD_W'(y_in);
    end
  end

  // 2^16 is -1 modulo 65537: low half minus high half
  always_comb begin
    diff = 18'(prod_r[15:0]) - 18'(prod_r[31:16]);
    if (diff[17]) begin
      y_out = ussc_pkg::Y_W'(diff + ussc_pkg::HASH_MOD);
    end else begin
      y_out = ussc_pkg::Y_W'(diff);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ussc_rem_unit.sv =====
// Remainder unit: restoring division, one dividend bit per cycle
`default_nettype none
module ussc_rem_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ussc_pkg::rem_req_t req,
  output ussc_pkg::rem_rsp_t      rsp
);

  logic                            busy_r;
  logic                            done_r;
  logic [ussc_pkg::DCNT_W-1:0]     cnt_r;
  logic [ussc_pkg::Y_W-1:0]        shift_r;
  logic [ussc_pkg::CCE_W-1:0]      rem_r;
  logic [ussc_pkg::CCE_W-1:0]      div_r;
  logic [ussc_pkg::CCE_W:0]        trial;
  logic [ussc_pkg::CCE_W:0]        trial_sub;

  always_comb begin
    trial     = {rem_r, shift_r[ussc_pkg::Y_W-1]};
    trial_sub = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ussc_pkg::DCNT_W'(ussc_pkg::Y_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ussc_pkg::DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      shift_r <= req.dividend;
      div_r   <= req.divisor;
      rem_r   <= '0;
    end else if (busy_r) begin
      shift_r <= shift_r << 1;
      if (trial >= {1'b0, div_r}) begin
        rem_r <= ussc_pkg::CCE_W'(trial_sub);
      end else begin
        rem_r <= ussc_pkg::CCE_W'(trial);
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

// ===== rtl/core/ue_search_space_candidates.sv =====
// Top level: UE-specific search space candidate generator with its sequencer
// Sequence: the hash steps of HMUL and HRED, subframe+1 of them, then per level with room
// the setup, the remainder unit, the hand-off and the first candidate, then one further
// candidate per cycle while the output takes them; a level without room only passes LVL.
// Throughput: one item at a time; a new item is taken only when the block is idle.
// Reset: synchronous, active low; cce_count returns to 16, the block goes idle.
`default_nettype none
module ue_search_space_candidates (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [ussc_pkg::CCE_W-1:0]    cfg_wdata,
  ussc_in_if.sink                            in_ch,
  ussc_out_if.source                         out_ch
);

  ussc_pkg::seq_state_t             state_r, state_nxt;
  logic [ussc_pkg::CCE_W-1:0]       cce_count_r;
  logic [ussc_pkg::Y_W-1:0]         y_r, y_nxt;
  logic [ussc_pkg::SF_W-1:0]        iter_r, iter_nxt;
  logic [ussc_pkg::SIZE_W-1:0]      size_r, size_nxt;
  logic [ussc_pkg::LVL_W-1:0]       lg_r, lg_nxt;
  logic [ussc_pkg::CCE_W-1:0]       slots_r, slots_nxt;
  logic [ussc_pkg::CAND_W-1:0]      cands_r, cands_nxt;
  logic [ussc_pkg::CAND_W-1:0]      m_r, m_nxt;
  logic [ussc_pkg::CCE_W-1:0]       r_r, r_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [ussc_pkg::LVL_W-1:0]       out_lvl_r, out_lvl_nxt;
  logic [ussc_pkg::CCE_W-1:0]       out_start_r, out_start_nxt;
  logic                             out_last_r, out_last_nxt;

  logic [ussc_pkg::Y_W-1:0]         y_hashed;
  logic [ussc_pkg::CCE_W-1:0]       slots_now;
  logic [ussc_pkg::CAND_W-1:0]      limit_now;
  logic [ussc_pkg::CCE_W-1:0]       r_inc;
  ussc_pkg::rem_req_t               rem_req;
  ussc_pkg::rem_rsp_t               rem_rsp;

  ussc_hash_step u_hash (
    .clk   (clk),
    .load  (state_r == ussc_pkg::ST_HMUL),
    .y_in  (y_r),
    .y_out (y_hashed)
  );

  ussc_rem_unit u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  always_comb begin
    slots_now = cce_count_r >> lg_r;
    limit_now = ussc_pkg::CAND_LIMIT[lg_r];
    r_inc     = r_r + 1'b1;

    rem_req.start    = (state_r == ussc_pkg::ST_LVL) && (slots_now != '0);
    rem_req.dividend = y_r;
    rem_req.divisor  = slots_now;

    state_nxt     = state_r;
    y_nxt         = y_r;
    iter_nxt      = iter_r;
    size_nxt      = size_r;
    lg_nxt        = lg_r;
    slots_nxt     = slots_r;
    cands_nxt     = cands_r;
    m_nxt         = m_r;
    r_nxt         = r_r;
    out_valid_nxt = out_valid_r;
    out_lvl_nxt   = out_lvl_r;
    out_start_nxt = out_start_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ussc_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          y_nxt     = ussc_pkg::Y_W'(in_ch.rnti);
          iter_nxt  = in_ch.subframe;
          size_nxt  = in_ch.payload_bits;
          state_nxt = ussc_pkg::ST_HMUL;
        end
      end
      ussc_pkg::ST_HMUL: begin
        state_nxt = ussc_pkg::ST_HRED;
      end
      ussc_pkg::ST_HRED: begin
        y_nxt = y_hashed;
        if (iter_r == '0) begin
          lg_nxt    = ussc_pkg::LVL_TOP;
          state_nxt = ussc_pkg::ST_LVL;
        end else begin
          iter_nxt  = iter_r - 1'b1;
          state_nxt = ussc_pkg::ST_HMUL;
        end
      end
      ussc_pkg::ST_LVL: begin
        slots_nxt = slots_now;
        m_nxt     = '0;
        if (ussc_pkg::CCE_W'(limit_now) > slots_now) begin
          cands_nxt = ussc_pkg::CAND_W'(slots_now);
        end else begin
          cands_nxt = limit_now;
        end
        if (slots_now != '0) begin
          state_nxt = ussc_pkg::ST_DIV;
        end else if (lg_r == ussc_pkg::LVL_ONE) begin
          state_nxt = ussc_pkg::ST_IDLE;
        end else begin
          lg_nxt = lg_r - 1'b1;
        end
      end
      ussc_pkg::ST_DIV: begin
        if (rem_rsp.done) begin
          r_nxt         = rem_rsp.rem;
          out_valid_nxt = 1'b1;
          out_lvl_nxt   = lg_r;
          out_start_nxt = ussc_pkg::CCE_W'(rem_rsp.rem << lg_r);
          out_last_nxt  = (lg_r == ussc_pkg::LVL_ONE) && (cands_r == ussc_pkg::CAND_W'(1));
          state_nxt     = ussc_pkg::ST_EMIT;
        end
      end
      ussc_pkg::ST_EMIT: begin
        if (out_ch.ready) begin
          if (m_r == cands_r - 1'b1) begin
            out_valid_nxt = 1'b0;
            if (lg_r == ussc_pkg::LVL_ONE) begin
              state_nxt = ussc_pkg::ST_IDLE;
            end else begin
              lg_nxt    = lg_r - 1'b1;
              state_nxt = ussc_pkg::ST_LVL;
            end
          end else begin
            m_nxt = m_r + 1'b1;
            if (r_inc == slots_r) begin
              r_nxt = '0;
            end else begin
              r_nxt = r_inc;
            end
            out_start_nxt = ussc_pkg::CCE_W'(r_nxt << lg_r);
            out_last_nxt  = (lg_r == ussc_pkg::LVL_ONE) && (m_nxt == cands_r - 1'b1);
          end
        end
      end
      default: begin
        state_nxt     = ussc_pkg::ST_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ussc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cce_count_r <= ussc_pkg::CCE_W'(16);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cce_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    y_r         <= y_nxt;
    iter_r      <= iter_nxt;
    size_r      <= size_nxt;
    lg_r        <= lg_nxt;
    slots_r     <= slots_nxt;
    cands_r     <= cands_nxt;
    m_r         <= m_nxt;
    r_r         <= r_nxt;
    out_lvl_r   <= out_lvl_nxt;
    out_start_r <= out_start_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ch.ready       = (state_r == ussc_pkg::ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.level_log2 = out_lvl_r;
  assign out_ch.start_cce  = out_start_r;
  assign out_ch.size_echo  = size_r;
  assign out_ch.last       = out_last_r;

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input taken while a candidate is pending");

  a_last_on_level_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last) |-> (out_ch.level_log2 == ussc_pkg::LVL_ONE))
    else $error("last flag on a level above one");

  a_start_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.start_cce < cce_count_r))
    else $error("candidate starts beyond the control region");

  a_rem_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_rsp.done |-> (state_r == ussc_pkg::ST_DIV))
    else $error("remainder finished outside the division step");
`endif

endmodule
`default_nettype wire
